>>> src/swfn_pkg.sv
// Shared constants and types for the sliding-window first-negative block.
`timescale 1ns / 1ps

package swfn_pkg;

    // Default sizes handed to the top level parameters.
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register layout.
    localparam int CFG_WIDTH  = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE  = 3'd0;
    localparam logic [CFG_WIDTH-1:0]  WINDOW_SIZE_RESET = 7'd1;

    // Status of the working stage, seen by the top level checks.
    typedef struct packed {
        logic stage_valid;
        logic stage_go;
    } swfn_stat_t;

endpackage

>>> src/sliding_window_first_negative_top.sv
// A sample beat is first captured in the working stage; its result is then registered in the output register.
// Throughput: one sample beat per cycle; the RAM read-modify-write stage sets the pace.
// A beat is held in the stage only while the output register is full and not taken.
// Reset clears the pointers, counters and stage; window_size returns to 1; no RAM sweep.
// Top level of the sliding-window first-negative block.
`timescale 1ns / 1ps

module sliding_window_first_negative_top #(
    parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swfn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swfn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swfn_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            last_sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   first_negative,
    output logic                            found
);

    import swfn_pkg::*;

    logic [CFG_WIDTH-1:0] window_size;
    swfn_stat_t           stat;

    // Configuration register.
    swfn_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_size (window_size)
    );

    // Datapath with the delay line and negative-sample FIFO.
    swfn_core #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size    (window_size),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .last_sample    (last_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_negative (first_negative),
        .found          (found),
        .stat           (stat)
    );

    // An accepted beat occupies the working stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> stat.stage_valid)
        else $error("accepted beat did not enter the stage");

    // A stalled stage must block new beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.stage_valid && !stat.stage_go) |-> !in_ready)
        else $error("new beat taken while the stage is stalled");

    // A found result is negative; a not-found result is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((found && first_negative[SAMPLE_BITS-1]) ||
                       (!found && (first_negative == '0))))
        else $error("result value does not match its found flag");

endmodule

>>> src/swfn_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module swfn_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read ports; a read at the written address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/swfn_cfg.sv
// APB-style configuration register holding the window size.
`timescale 1ns / 1ps

module swfn_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swfn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swfn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swfn_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [swfn_pkg::CFG_WIDTH-1:0]  window_size
);

    import swfn_pkg::*;

    logic                 hit;
    logic                 wr_en;
    logic [CFG_WIDTH-1:0] window_size_reg;
    logic [CFG_WIDTH-1:0] window_size_next;

    // Address decode and write strobe in the access phase.
    assign hit    = (paddr == ADDR_WINDOW_SIZE);
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;

    always_comb
    begin
        window_size_next = window_size_reg;
        if (wr_en)
        begin
            window_size_next = pwdata[CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    // Read back the register, zero-extended.
    assign prdata      = hit ? APB_DATA_W'(window_size_reg) : '0;
    assign window_size = window_size_reg;

endmodule

>>> src/swfn_core.sv
// Delay line and negative-sample FIFO held in RAMs, with a read-modify-write stage.
`timescale 1ns / 1ps

module swfn_core #(
    parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [swfn_pkg::CFG_WIDTH-1:0] window_size,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic                           last_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_BITS-1:0]  first_negative,
    output logic                           found,
    output swfn_pkg::swfn_stat_t           stat
);

    import swfn_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (KW > CFG_WIDTH) ? KW : CFG_WIDTH;

    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [KW-1:0] K_MAX    = KW'(WINDOW_MAX);
    localparam logic [KW:0]   K_MAX_X  = (KW + 1)'(WINDOW_MAX);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + AW'(1);
    endfunction

    // Architectural state.
    logic [AW-1:0] wp_reg, wp_next;
    logic [KW-1:0] seq_count_reg, seq_count_next;
    logic [KW-1:0] fill_reg, fill_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [KW-1:0] cnt_reg, cnt_next;

    // Working stage: the item whose RAM reads are in flight.
    logic                   st_valid_reg, st_valid_next;
    logic [SAMPLE_BITS-1:0] st_sample_reg;
    logic                   st_last_reg;
    logic                   st_win_ok_reg;
    logic                   st_win_fwd_reg;
    logic                   st_win_fwd_neg_reg;
    logic                   st_fifo_fwd_reg;
    logic [SAMPLE_BITS-1:0] st_fifo_fwd_data_reg;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic                   out_found_reg;

    logic [CW-1:0]          ws_ext;
    logic [CW-1:0]          k_sel;
    logic [KW-1:0]          k;
    logic [KW-1:0]          km1;
    logic                   k_one;
    logic                   st_res;
    logic                   out_free;
    logic                   st_go;
    logic                   accept;
    logic                   s_neg;
    logic                   push;
    logic                   pop;
    logic [KW-1:0]          cnt_push;
    logic                   found_now;
    logic [SAMPLE_BITS-1:0] head_data;
    logic                   oldest_neg;
    logic [KW:0]            old_sum;
    logic [KW:0]            old_adj;
    logic [AW-1:0]          rd_win_addr;
    logic                   rd_win_ok;
    logic                   rd_win_fwd;
    logic                   rd_fifo_fwd;
    logic [SAMPLE_BITS-1:0] win_rdata;
    logic [SAMPLE_BITS-1:0] fifo_rdata;

    // Effective window size: zero counts as one, large values saturate.
    assign ws_ext = CW'(window_size);
    assign k_sel  = (ws_ext == '0) ? CW'(1) :
                    (ws_ext > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : ws_ext;
    assign k      = KW'(k_sel);
    assign km1    = k - KW'(1);
    assign k_one  = (k == KW'(1));

    // Stage handshake: an item that gives a result needs a free output register.
    assign st_res   = (fill_reg >= km1);
    assign out_free = !out_valid_reg || out_ready;
    assign st_go    = st_valid_reg && (!st_res || out_free);
    assign in_ready = !st_valid_reg || st_go;
    assign accept   = in_valid && in_ready;

    // FIFO push and head value, with the new sample standing in when the FIFO was empty.
    assign s_neg     = st_sample_reg[SAMPLE_BITS-1];
    assign push      = st_go && s_neg && (cnt_reg != K_MAX);
    assign cnt_push  = cnt_reg + KW'(push);
    assign found_now = (cnt_push != '0);
    assign head_data = (cnt_reg == '0) ? st_sample_reg :
                       (st_fifo_fwd_reg ? st_fifo_fwd_data_reg : fifo_rdata);

    // Sign of the sample leaving the window; unwritten slots read as zero.
    assign oldest_neg = k_one ? s_neg :
                        (st_win_ok_reg &&
                         (st_win_fwd_reg ? st_win_fwd_neg_reg : win_rdata[SAMPLE_BITS-1]));
    assign pop        = st_go && st_res && oldest_neg && found_now;

    // State update for the item in the stage; the last sample clears everything.
    always_comb
    begin
        wp_next        = wp_reg;
        seq_count_next = seq_count_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        if (st_go)
        begin
            wp_next        = ptr_inc(wp_reg);
            seq_count_next = (seq_count_reg == K_MAX) ? seq_count_reg
                                                      : seq_count_reg + KW'(1);
            fill_next      = st_res ? fill_reg : fill_reg + KW'(1);
            tail_next      = push ? ptr_inc(tail_reg) : tail_reg;
            head_next      = pop ? ptr_inc(head_reg) : head_reg;
            cnt_next       = cnt_push - KW'(pop);
            if (st_last_reg)
            begin
                wp_next        = '0;
                seq_count_next = '0;
                fill_next      = '0;
                head_next      = '0;
                tail_next      = '0;
                cnt_next       = '0;
            end
        end
    end

    // Read addresses for the incoming beat, taken from the updated state.
    assign old_sum     = {1'b0, KW'(wp_next)} + K_MAX_X - {1'b0, km1};
    assign old_adj     = (old_sum >= K_MAX_X) ? old_sum - K_MAX_X : old_sum;
    assign rd_win_addr = AW'(old_adj);
    assign rd_win_ok   = (KW'(rd_win_addr) < seq_count_next);
    assign rd_win_fwd  = st_go && (rd_win_addr == wp_reg);
    assign rd_fifo_fwd = push && (head_next == tail_reg);

    // Stage occupancy and output register control.
    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = 1'b1;
        end
        else if (st_go)
        begin
            st_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (st_go && st_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            seq_count_reg <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            seq_count_reg <= seq_count_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payload and forwarding flags, captured with the beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_sample_reg        <= sample;
            st_last_reg          <= last_sample;
            st_win_ok_reg        <= rd_win_ok;
            st_win_fwd_reg       <= rd_win_fwd;
            st_win_fwd_neg_reg   <= s_neg;
            st_fifo_fwd_reg      <= rd_fifo_fwd;
            st_fifo_fwd_data_reg <= st_sample_reg;
        end
        if (st_go && st_res)
        begin
            out_data_reg  <= found_now ? head_data : '0;
            out_found_reg <= found_now;
        end
    end

    // Delay line of recent samples.
    swfn_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_window_ram (
        .clk   (clk),
        .we    (st_go),
        .waddr (wp_reg),
        .wdata (st_sample_reg),
        .re    (accept),
        .raddr (rd_win_addr),
        .rdata (win_rdata)
    );

    // Negative samples still inside the window, oldest at the head.
    swfn_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (st_sample_reg),
        .re    (accept),
        .raddr (head_next),
        .rdata (fifo_rdata)
    );

    assign out_valid        = out_valid_reg;
    assign first_negative   = out_data_reg;
    assign found            = out_found_reg;
    assign stat.stage_valid = st_valid_reg;
    assign stat.stage_go    = st_go;

endmodule

>>> dv/tb_sliding_window_first_negative_top.sv
// Self-checking testbench for the sliding-window first-negative block.
`timescale 1ns / 1ps

module tb_sliding_window_first_negative_top;

    import swfn_pkg::*;

    localparam int SW   = SAMPLE_BITS_DEF;
    localparam int WMAX = WINDOW_MAX_DEF;

    // One sample beat waiting to be driven.
    typedef struct {
        logic [SW-1:0] smp;
        logic          last;
    } sample_beat_t;

    // One predicted result beat.
    typedef struct {
        logic [SW-1:0] neg;
        logic          hit;
    } first_neg_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [SW-1:0]  sample = '0;
    logic                  last_sample = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [SW-1:0]  first_negative;
    logic                  found;

    // Stimulus and scoreboard storage.
    sample_beat_t sample_beats[$];
    first_neg_t   expected_first_neg[$];
    int unsigned  beats_queued = 0;
    int unsigned  beats_taken = 0;
    int unsigned  bad_results = 0;
    int unsigned  in_idle_pct = 8;
    int unsigned  out_idle_pct = 8;
    logic         hold_go = 1'b0;
    logic         out_hold = 1'b0;

    // Shadow copy of the block state.
    logic [6:0]    size_reg = WINDOW_SIZE_RESET;
    logic [SW-1:0] win_mem[WMAX];
    logic [SW-1:0] neg_mem[WMAX];
    int unsigned   win_wr;
    int unsigned   seen_cnt;
    int unsigned   neg_head;
    int unsigned   neg_tail;
    int unsigned   neg_cnt;

    sliding_window_first_negative_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .last_sample    (last_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_negative (first_negative),
        .found          (found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the window and the negative FIFO, as at reset or after a last beat.
    function automatic void clear_window_state();
        for (int i = 0; i < WMAX; i++)
        begin
            win_mem[i] = '0;
            neg_mem[i] = '0;
        end
        win_wr   = 0;
        seen_cnt = 0;
        neg_head = 0;
        neg_tail = 0;
        neg_cnt  = 0;
    endfunction

    // Advance the shadow state by one sample and queue the result it gives.
    function automatic void step_first_negative(input logic [SW-1:0] s, input logic last);
        int unsigned k;
        int unsigned oldest;
        first_neg_t  res;
        k = (size_reg == 0) ? 1 : ((size_reg > WMAX) ? WMAX : size_reg);
        win_mem[win_wr] = s;
        if (s[SW-1] && neg_cnt < WMAX)
        begin
            neg_mem[neg_tail] = s;
            neg_tail = (neg_tail + 1) % WMAX;
            neg_cnt++;
        end
        if (seen_cnt < k - 1)
        begin
            seen_cnt++;
        end
        else
        begin
            res.hit = (neg_cnt != 0);
            res.neg = res.hit ? neg_mem[neg_head] : '0;
            expected_first_neg.insert(expected_first_neg.size(), res);
            // The sample about to leave the window drops out of the FIFO.
            oldest = (win_wr + WMAX - (k - 1)) % WMAX;
            if (win_mem[oldest][SW-1] && neg_cnt > 0)
            begin
                neg_head = (neg_head + 1) % WMAX;
                neg_cnt--;
            end
        end
        win_wr = (win_wr + 1) % WMAX;
        if (last)
            clear_window_state();
    endfunction

    // Sample driver: holds each beat until taken, idles at random.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_beat_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sample      <= '0;
            last_sample <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_first_negative(sample, last_sample);
                beats_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_beats.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    nxt = sample_beats.pop_front();
                    in_valid    <= 1'b1;
                    sample      <= nxt.smp;
                    last_sample <= nxt.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each taken beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        first_neg_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_first_neg.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result beat: first_negative=%0d found=%0b",
                                 first_negative, found);
                end
                else
                begin
                    exp_res = expected_first_neg.pop_front();
                    if (first_negative !== exp_res.neg || found !== exp_res.hit)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                                     $signed(exp_res.neg), exp_res.hit,
                                     first_negative, found);
                    end
                end
            end
            out_ready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (250) @(posedge clk);
        out_hold <= 1'b0;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("tb_sliding_window_first_negative_top NOT OK");
        $finish;
    end

    task automatic queue_beat(input logic [SW-1:0] s, input logic last);
        sample_beat_t b;
        b.smp  = s;
        b.last = last;
        sample_beats.insert(sample_beats.size(), b);
        beats_queued++;
    endtask

    // Wait until every beat is taken and every result is back, then let the pipe settle.
    task automatic wait_idle();
        while (beats_taken != beats_queued || expected_first_neg.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write over the APB port, setup then access.
    task automatic write_window_size(input logic [6:0] value);
        logic [APB_DATA_W-1:0] bits;
        bits = $urandom();
        bits[CFG_WIDTH-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_SIZE;
        pwdata  <= bits;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = value;
    endtask

    // Random sample, negative or not, with extremes mixed in.
    function automatic logic [SW-1:0] pick_sample(input bit negative);
        logic [SW-1:0] v;
        v = SW'($urandom());
        case ($urandom_range(9))
            0: v = negative ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            1: v = negative ? {SW{1'b1}} : '0;
            default: v[SW-1] = negative;
        endcase
        return v;
    endfunction

    task automatic queue_sequence(input int unsigned len, input int unsigned neg_pct,
                                  input bit close_it);
        for (int unsigned i = 0; i < len; i++)
            queue_beat(pick_sample($urandom_range(99) < neg_pct),
                       close_it && (i == len - 1));
    endtask

    // Random sequences for the current window size, mostly long enough to give results.
    task automatic queue_random_phase(input int unsigned n_items);
        int unsigned k;
        int unsigned len;
        int unsigned neg_pct;
        int unsigned done;
        int unsigned pcts[5];
        bit          close_it;
        pcts = '{0, 15, 50, 90, 100};
        k = (size_reg == 0) ? 1 : ((size_reg > WMAX) ? WMAX : size_reg);
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(99) < 15)
                len = $urandom_range(k, 1);
            else
                len = k + $urandom_range(k + 20);
            // The phase ends at its item budget.
            if (len > n_items - done)
                len = n_items - done;
            neg_pct = pcts[$urandom_range(4)];
            close_it = (done + len < n_items) || ($urandom_range(99) < 70);
            queue_sequence(len, neg_pct, close_it);
            done += len;
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several sizes.
    initial
    begin
        logic [6:0] sizes[12];
        sizes = '{7'd1, 7'd2, 7'd3, 7'd7, 7'd16, 7'd33, 7'd64, 7'd0, 7'd127, 7'd65, 7'd5,
                  7'd12};
        clear_window_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset window size of one: every beat gives a result.
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'shffff, 1'b0);
        queue_beat(16'sh0001, 1'b1);
        wait_idle();

        // Window of three: oldest negative, its removal, then a window with none.
        write_window_size(7'd3);
        queue_beat(-16'sd5, 1'b0);
        queue_beat(16'sd7, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sd3, 1'b0);
        queue_beat(16'sd2, 1'b0);
        queue_beat(16'sd4, 1'b0);
        queue_beat(16'sd6, 1'b1);
        wait_idle();

        // Size zero behaves as one.
        write_window_size(7'd0);
        queue_beat(-16'sd2, 1'b0);
        queue_beat(16'sd5, 1'b1);
        wait_idle();

        // Sequence that ends before the window fills gives nothing.
        write_window_size(7'd5);
        queue_beat(16'sd9, 1'b0);
        queue_beat(-16'sd9, 1'b0);
        queue_beat(16'sd8, 1'b1);
        wait_idle();

        // Window grows in the middle of a sequence.
        write_window_size(7'd2);
        queue_sequence(4, 50, 1'b0);
        wait_idle();
        write_window_size(7'd10);
        queue_sequence(12, 50, 1'b1);
        wait_idle();

        // Oversized window saturates; shrinking it leaves stale FIFO entries, and a
        // window of two with mixed signs then fills the FIFO up.
        write_window_size(7'd127);
        queue_sequence(70, 100, 1'b0);
        wait_idle();
        write_window_size(7'd1);
        queue_sequence(70, 100, 1'b0);
        wait_idle();
        write_window_size(7'd2);
        queue_sequence(20, 50, 1'b0);
        queue_sequence(10, 0, 1'b1);
        wait_idle();

        // Random phases.
        for (int p = 0; p < 12; p++)
        begin
            write_window_size(p == 11 ? 7'($urandom_range(64, 1)) : sizes[p]);
            if (p == 5)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct  = 8;
                out_idle_pct = 8;
            end
            queue_random_phase(90);
            if (p == 3)
                hold_go = 1'b1;
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (bad_results == 0 && expected_first_neg.size() == 0)
            $display("tb_sliding_window_first_negative_top OK");
        else
            $display("tb_sliding_window_first_negative_top NOT OK");
        $finish;
    end

endmodule
